[design/lpfs_pkg.sv]
// ----------------------------------------------------------------------------
// lpfs_pkg: shared types and constants of the least-prime-factor sieve
// Holds the item operation codes, the result status codes and the field
// widths of one result item.
// ----------------------------------------------------------------------------
package lpfs_pkg;

	// Fixed field widths of the item ports.
	localparam int unsigned FIELD_W    = 16;
	localparam int unsigned EXP_W      = 5;
	localparam int unsigned TOTAL_W    = 14;
	localparam int unsigned MAX_RESULTS = 6;
	localparam int unsigned RES_CNT_W  = $clog2(MAX_RESULTS);

	// Item operations, as carried on the op port.
	localparam logic OP_BUILD  = 1'b0;
	localparam logic OP_FACTOR = 1'b1;

	typedef enum logic [1:0] {
		STAT_FACTOR       = 2'd0,
		STAT_BUILD_DONE   = 2'd1,
		STAT_NO_FACTOR    = 2'd2,
		STAT_OUT_OF_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		status_t             status;
		logic [FIELD_W-1:0]  prime;
		logic [EXP_W-1:0]    exponent;
		logic [TOTAL_W-1:0]  prime_total;
		logic                last;
	} result_t;

endpackage

[design/lpfs_ram.sv]
// ----------------------------------------------------------------------------
// lpfs_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lpfs_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/least_prime_factor_sieve_top.sv]
// ----------------------------------------------------------------------------
// least_prime_factor_sieve_top: linear sieve and prime factorization engine
// Builds least-prime-factor and cofactor tables plus a prime list in RAM,
// then factors values by walking those tables.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A build item, or a
// factor item that walks the tables, raises busy on the next cycle and drops
// it in the cycle where its last result item shows; a rejected factor item
// never raises busy. A build item (op = 0) first clears table entries 0
// through L (L is sieve_limit, clamped to 2..MAX_VALUE), and then visits
// every n from 2 to L: it reads the table entry of n (S_N_RD, S_N_CHK), then
// tries primes in turn (S_P_RD, S_P_MUL, S_P_CHK), which is each prime it
// marks a multiple with and at most one more that ends the loop. All of this
// runs through the single read port of the tables and the one multiplier.
// It ends in one result item with the prime count.
// A factor item (op = 1) walks the tables with S_F_RD and S_F_CHK, one read
// per prime power step plus one per change of prime. A 16-bit value needs
// at most sixteen reads (49152, which is 2^14 times 3, is such a value). A
// rejected value (not built, zero, one or above the built limit) gets its
// single result item in the cycle after it is taken.
// Result items appear for exactly one cycle, marked by result_strobe; the
// receiver cannot stall them, so it must take each item when it shows.
// The last result item of every input item has last set. The sieve_limit
// register is written through the cfg channel, which is always ready, and
// is only sampled when a build starts.
// ----------------------------------------------------------------------------
module least_prime_factor_sieve_top
	import lpfs_pkg::*;
#(
	parameter int unsigned MAX_VALUE   = 65535,
	parameter int unsigned PRIME_SLOTS = 8192
) (
	input  logic               clk,
	input  logic               arst_n,
	// Item input
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [15:0]        value,
	// Configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	// Result output
	output logic               result_strobe,
	output logic [1:0]         status,
	output logic [15:0]        prime,
	output logic [4:0]         exponent,
	output logic [13:0]        prime_total,
	output logic               last
);

	// Widths that follow from the parameters.
	localparam int unsigned AW = $clog2(MAX_VALUE + 1);      // table value/address
	localparam int unsigned PW = $clog2(PRIME_SLOTS);        // prime list address
	localparam int unsigned TW = $clog2(PRIME_SLOTS + 1);    // prime tally

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CLEAR = 9'b000000010,
		S_N_RD  = 9'b000000100,
		S_N_CHK = 9'b000001000,
		S_P_RD  = 9'b000010000,
		S_P_MUL = 9'b000100000,
		S_P_CHK = 9'b001000000,
		S_F_RD  = 9'b010000000,
		S_F_CHK = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [15:0]         sieve_limit_q;
	logic [AW-1:0]       lim_q;
	logic [AW-1:0]       built_q;
	logic [AW-1:0]       n_q;
	logic [AW-1:0]       lpf_n_q;
	logic [AW-1:0]       p_q;
	logic [2*AW-1:0]     prod_q;
	logic [TW-1:0]       tally_q;
	logic [TW-1:0]       i_q;
	logic [AW-1:0]       cur_p_q;
	logic [EXP_W-1:0]    e_q;
	logic [RES_CNT_W-1:0] k_q;
	result_t             res_q;
	logic                strobe_q;

	// Table RAM holds {least prime factor, cofactor} per entry.
	logic                tab_we;
	logic [AW-1:0]       tab_waddr;
	logic [2*AW-1:0]     tab_wdata;
	logic                tab_re;
	logic [2*AW-1:0]     tab_rdata;
	logic [AW-1:0]       tab_lpf;
	logic [AW-1:0]       tab_cof;

	logic                pr_we;
	logic                pr_re;
	logic [AW-1:0]       pr_rdata;

	logic [31:0]         lim_wide;
	logic [AW-1:0]       lim_clamp;
	logic                is_prime;
	logic                can_store;
	logic [TW-1:0]       tally_nx;
	logic                brk;
	logic                f_match;
	logic [EXP_W-1:0]    e_nx;
	logic [AW-1:0]       n_nx;
	logic [TW-1:0]       i_nx;

	assign tab_lpf = tab_rdata[2*AW-1:AW];
	assign tab_cof = tab_rdata[AW-1:0];

	// Limit clamping for a new build.
	always_comb begin
		lim_wide = 32'(sieve_limit_q);
		if (lim_wide < 32'd2) begin
			lim_wide = 32'd2;
		end
		if (lim_wide > 32'(MAX_VALUE)) begin
			lim_wide = 32'(MAX_VALUE);
		end
		lim_clamp = AW'(lim_wide);
	end

	// Sieve decisions.
	assign is_prime  = (tab_lpf == '0);
	assign can_store = (tally_q < TW'(PRIME_SLOTS));
	assign tally_nx  = tally_q + TW'(is_prime && can_store);
	assign brk       = (p_q > lpf_n_q) || (prod_q > (2*AW)'(lim_q));
	assign i_nx      = i_q + TW'(1);

	// Factor walk decisions. A cofactor that does not shrink ends the walk.
	assign f_match = (e_q == '0) || (tab_lpf == cur_p_q);
	assign e_nx    = e_q + EXP_W'(1);
	assign n_nx    = (tab_cof >= n_q) ? AW'(1) : tab_cof;

	// RAM port control.
	always_comb begin
		tab_we    = 1'b0;
		tab_waddr = n_q;
		tab_wdata = '0;
		if (state_q == S_CLEAR) begin
			tab_we = 1'b1;
		end else if (state_q == S_N_CHK) begin
			tab_we    = is_prime;
			tab_wdata = {n_q, AW'(1)};
		end else if (state_q == S_P_CHK) begin
			tab_we    = !brk;
			tab_waddr = prod_q[AW-1:0];
			tab_wdata = {p_q, n_q};
		end
	end

	assign tab_re = (state_q == S_N_RD) || (state_q == S_F_RD);
	assign pr_we  = (state_q == S_N_CHK) && is_prime && can_store;
	assign pr_re  = (state_q == S_P_RD);

	lpfs_ram #(
		.WIDTH (2 * AW),
		.DEPTH (MAX_VALUE + 1)
	) u_table_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (tab_re),
		.raddr (n_q),
		.rdata (tab_rdata)
	);

	lpfs_ram #(
		.WIDTH (AW),
		.DEPTH (PRIME_SLOTS)
	) u_prime_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (tally_q[PW-1:0]),
		.wdata (n_q),
		.re    (pr_re),
		.raddr (i_q[PW-1:0]),
		.rdata (pr_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= 16'hFFFF;
		end else if (cfg_valid) begin
			sieve_limit_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			built_q  <= '0;
			tally_q  <= '0;
			strobe_q <= 1'b0;
			lim_q    <= '0;
			n_q      <= '0;
			lpf_n_q  <= '0;
			p_q      <= '0;
			prod_q   <= '0;
			i_q      <= '0;
			cur_p_q  <= '0;
			e_q      <= '0;
			k_q      <= '0;
			res_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (op == OP_BUILD) begin
							lim_q   <= lim_clamp;
							n_q     <= '0;
							tally_q <= '0;
							state_q <= S_CLEAR;
						end else if (built_q == '0 || 32'(value) > 32'(built_q)) begin
							strobe_q <= 1'b1;
							res_q    <= '{STAT_OUT_OF_RANGE, '0, '0, '0, 1'b1};
						end else if (value < 16'd2) begin
							strobe_q <= 1'b1;
							res_q    <= '{STAT_NO_FACTOR, '0, '0, '0, 1'b1};
						end else begin
							n_q     <= AW'(value);
							e_q     <= '0;
							k_q     <= '0;
							state_q <= S_F_RD;
						end
					end
				end
				S_CLEAR: begin
					if (n_q == lim_q) begin
						n_q     <= AW'(2);
						state_q <= S_N_RD;
					end else begin
						n_q <= n_q + AW'(1);
					end
				end
				S_N_RD: begin
					state_q <= S_N_CHK;
				end
				S_N_CHK: begin
					lpf_n_q <= is_prime ? n_q : tab_lpf;
					tally_q <= tally_nx;
					i_q     <= '0;
					if (tally_nx != '0) begin
						state_q <= S_P_RD;
					end else if (n_q == lim_q) begin
						built_q  <= lim_q;
						strobe_q <= 1'b1;
						res_q    <= '{STAT_BUILD_DONE, '0, '0, TOTAL_W'(tally_nx), 1'b1};
						state_q  <= S_IDLE;
					end else begin
						n_q     <= n_q + AW'(1);
						state_q <= S_N_RD;
					end
				end
				S_P_RD: begin
					state_q <= S_P_MUL;
				end
				S_P_MUL: begin
					p_q     <= pr_rdata;
					prod_q  <= (2*AW)'(n_q) * (2*AW)'(pr_rdata);
					state_q <= S_P_CHK;
				end
				S_P_CHK: begin
					i_q <= i_nx;
					if (!brk && i_nx < tally_q) begin
						state_q <= S_P_RD;
					end else if (n_q == lim_q) begin
						built_q  <= lim_q;
						strobe_q <= 1'b1;
						res_q    <= '{STAT_BUILD_DONE, '0, '0, TOTAL_W'(tally_q), 1'b1};
						state_q  <= S_IDLE;
					end else begin
						n_q     <= n_q + AW'(1);
						state_q <= S_N_RD;
					end
				end
				S_F_RD: begin
					state_q <= S_F_CHK;
				end
				S_F_CHK: begin
					if (f_match) begin
						if (e_q == '0) begin
							cur_p_q <= tab_lpf;
						end
						if (n_nx < AW'(2)) begin
							// The value is fully divided out: close the open prime.
							strobe_q <= 1'b1;
							res_q    <= '{STAT_FACTOR,
								FIELD_W'((e_q == '0) ? tab_lpf : cur_p_q), e_nx, '0, 1'b1};
							state_q  <= S_IDLE;
						end else begin
							n_q     <= n_nx;
							e_q     <= e_nx;
							state_q <= S_F_RD;
						end
					end else begin
						// A new prime shows up: report the finished one and, unless it fills the
						// last result slot, reread the same entry to open the next group.
						strobe_q <= 1'b1;
						res_q    <= '{STAT_FACTOR, FIELD_W'(cur_p_q), e_q, '0,
							k_q == RES_CNT_W'(MAX_RESULTS - 1)};
						k_q      <= k_q + RES_CNT_W'(1);
						e_q      <= '0;
						if (k_q == RES_CNT_W'(MAX_RESULTS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_F_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_strobe = strobe_q;
	assign status        = res_q.status;
	assign prime         = res_q.prime;
	assign exponent      = res_q.exponent;
	assign prime_total   = res_q.prime_total;
	assign last          = res_q.last;

endmodule
